// ----- rtl/fqs_pkg.sv -----
// Shared types and constants of the FIFO queue with search.
`default_nettype none

package fqs_pkg;

  // Default number of entries in the queue store.
  localparam int unsigned DefDepth = 16;

  // Fixed field widths of the beats.
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // Operation codes carried by the func field.
  typedef enum logic [FuncW-1:0] {
    FUNC_EMPTY  = 3'd0,
    FUNC_ENQ    = 3'd1,
    FUNC_DEQ    = 3'd2,
    FUNC_FRONT  = 3'd3,
    FUNC_REAR   = 3'd4,
    FUNC_SEARCH = 3'd5
  } func_e;

  // Status codes of a result beat.
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Controller sequencing states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_SEARCH = 2'd2,
    S_EMIT   = 2'd3
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/fqs_ram.sv -----
// Entry store of the queue: one write port and one read port with registered read data.
`default_nettype none

module fqs_ram #(
  parameter int unsigned Depth = fqs_pkg::DefDepth,
  parameter int unsigned Width = fqs_pkg::ValueW,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Synchronous write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Synchronous read; the read data is registered and valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/fqs_ctrl.sv -----
// Queue controller: pointers, operation sequencer, search walk and output register.
`default_nettype none

module fqs_ctrl #(
  parameter int unsigned Depth = fqs_pkg::DefDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic        [fqs_pkg::FuncW-1:0]  func_i,
  input  wire logic signed [fqs_pkg::ValueW-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic             [fqs_pkg::StatusW-1:0] status_o,
  output logic signed      [fqs_pkg::ValueW-1:0] data_o,
  output logic                                   found_at_rear_o,
  output logic                                   ram_we_o,
  output logic             [AddrW-1:0]           ram_waddr_o,
  output logic             [fqs_pkg::ValueW-1:0] ram_wdata_o,
  output logic                                   ram_re_o,
  output logic             [AddrW-1:0]           ram_raddr_o,
  input  wire logic        [fqs_pkg::ValueW-1:0] ram_rdata_i
);

  import fqs_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);

  // Circular index step forward.
  function automatic logic [AddrW-1:0] idx_next(input logic [AddrW-1:0] idx);
    logic [AddrW-1:0] res;
    res = (idx == AddrW'(Depth - 1)) ? '0 : idx + AddrW'(1);
    return res;
  endfunction

  // Circular index step back.
  function automatic logic [AddrW-1:0] idx_prev(input logic [AddrW-1:0] idx);
    logic [AddrW-1:0] res;
    res = (idx == '0) ? AddrW'(Depth - 1) : idx - AddrW'(1);
    return res;
  endfunction

  state_e                state_q, state_d;
  logic [AddrW-1:0]      head_q, head_d;
  logic [AddrW-1:0]      tail_q, tail_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [AddrW-1:0]      ptr_q, ptr_d;
  logic [CntW-1:0]       rem_q, rem_d;
  logic                  hit_q, hit_d;
  logic [ValueW-1:0]     value_q, value_d;
  status_e               res_status_q, res_status_d;
  logic [ValueW-1:0]     res_data_q, res_data_d;
  logic                  res_rear_q, res_rear_d;
  logic                  out_valid_q, out_valid_d;
  logic [StatusW-1:0]    out_status_q;
  logic [ValueW-1:0]     out_data_q;
  logic                  out_rear_q;
  logic                  load_out;
  logic                  empty;
  logic                  full;
  logic                  eq;

  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(Depth));
  assign eq    = (ram_rdata_i == value_q);

  // Sequencer: next state, pointer updates and store accesses.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    rem_d        = rem_q;
    hit_d        = hit_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_rear_d   = res_rear_q;
    in_ready_o   = 1'b0;
    load_out     = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = tail_q;
    ram_wdata_o  = value_i;
    ram_re_o     = 1'b0;
    ram_raddr_o  = head_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          value_d      = value_i;
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_rear_d   = 1'b0;
          hit_d        = 1'b0;
          state_d      = S_EMIT;
          case (func_e'(func_i))
            FUNC_EMPTY: begin
              res_status_d = empty ? ST_EMPTY : ST_OK;
            end
            FUNC_ENQ: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we_o = 1'b1;
                tail_d   = idx_next(tail_q);
                count_d  = count_q + CntW'(1);
              end
            end
            FUNC_DEQ: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_re_o = 1'b1;
                head_d   = idx_next(head_q);
                count_d  = count_q - CntW'(1);
                state_d  = S_READ;
              end
            end
            FUNC_FRONT: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_re_o = 1'b1;
                state_d  = S_READ;
              end
            end
            FUNC_REAR: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = idx_prev(tail_q);
                state_d     = S_READ;
              end
            end
            FUNC_SEARCH: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                // Walk from the oldest entry; the last one compared is the rear.
                ram_re_o = 1'b1;
                ptr_d    = idx_next(head_q);
                rem_d    = count_q - CntW'(1);
                state_d  = S_SEARCH;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        res_data_d = ram_rdata_i;
        state_d    = S_EMIT;
      end
      S_SEARCH: begin
        if (rem_q == '0) begin
          res_status_d = (hit_q || eq) ? ST_OK : ST_NOTFOUND;
          res_rear_d   = eq;
          state_d      = S_EMIT;
        end else begin
          hit_d       = hit_q | eq;
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q;
          ptr_d       = idx_next(ptr_q);
          rem_d       = rem_q - CntW'(1);
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat valid flag.
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    rem_q        <= rem_d;
    hit_q        <= hit_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_rear_q   <= res_rear_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_rear_q   <= res_rear_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign data_o          = out_data_q;
  assign found_at_rear_o = out_rear_q;

endmodule

`default_nettype wire

// ----- rtl/fifo_queue_with_search_top.sv -----
// Top level of the FIFO queue of signed words with linear search.
`default_nettype none

// A first-in first-out queue of DEPTH signed 32-bit words. Each input beat carries an
// operation (empty test, enqueue, dequeue, front, rear, search) and a value; each one
// yields exactly one result beat with a status, a data word and, for a search, a flag
// telling whether the newest entry matches. Items are handled one at a time. Empty
// test, enqueue and every error case go from the accepting edge to the emit state,
// which loads the output register; dequeue, front and rear pass first through the
// read state, since the entry store has registered read data; a search walks the
// single read port of the store one entry a cycle from the oldest to the newest entry
// held, then goes to the emit state. The sequencer then returns to idle to take the
// next beat. A new input beat is taken in the cycle after the previous result enters
// the output register, even while that result still waits for the consumer; a
// finished result that finds the output register still full holds the sequencer until
// it drains.
module fifo_queue_with_search_top #(
  parameter int unsigned DEPTH = fqs_pkg::DefDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic        [fqs_pkg::FuncW-1:0]   func_i,
  input  wire logic signed [fqs_pkg::ValueW-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic             [fqs_pkg::StatusW-1:0] status_o,
  output logic signed      [fqs_pkg::ValueW-1:0]  data_o,
  output logic                                    found_at_rear_o
);

  import fqs_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  // Sequencer and output register.
  fqs_ctrl #(
    .Depth(DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .data_o         (data_o),
    .found_at_rear_o(found_at_rear_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // Entry store.
  fqs_ram #(
    .Depth(DEPTH),
    .Width(ValueW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire
